// ===== hw/rtl/tccw_pkg.sv =====
package tccw_pkg;

	localparam logic [7:0] ATTR_RESET   = 8'h0F;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_TAB       = 8'h09;

	typedef enum logic [2:0] {
		REQ_PUT      = 3'd0,
		REQ_PUT_ATTR = 3'd1,
		REQ_WRITE    = 3'd2,
		REQ_SET      = 3'd3,
		REQ_CLEAR    = 3'd4,
		REQ_READ     = 3'd5
	} req_code_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] char_code;
		logic [7:0] cell_attr;
		logic [7:0] target_row;
		logic [7:0] target_col;
	} req_item_t;

	typedef struct packed {
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [15:0] read_data;
	} rsp_item_t;

	typedef logic [4:0] step_t;

	localparam step_t ST_INIT      = 5'd0;
	localparam step_t ST_INIT_LP   = 5'd1;
	localparam step_t ST_DISP      = 5'd2;
	localparam step_t ST_PUT       = 5'd3;
	localparam step_t ST_NL        = 5'd4;
	localparam step_t ST_CR        = 5'd5;
	localparam step_t ST_BS        = 5'd6;
	localparam step_t ST_BS_DEC    = 5'd7;
	localparam step_t ST_BS_WR     = 5'd8;
	localparam step_t ST_WC        = 5'd9;
	localparam step_t ST_WC_WR     = 5'd10;
	localparam step_t ST_SET       = 5'd11;
	localparam step_t ST_CLR       = 5'd12;
	localparam step_t ST_CLR_LP    = 5'd13;
	localparam step_t ST_RD        = 5'd14;
	localparam step_t ST_RD_ADR    = 5'd15;
	localparam step_t ST_RD_CAP    = 5'd16;
	localparam step_t ST_SC        = 5'd17;
	localparam step_t ST_SC_PRE    = 5'd18;
	localparam step_t ST_SC_LP     = 5'd19;
	localparam step_t ST_SC_BLK    = 5'd20;
	localparam step_t ST_SC_BLK_LP = 5'd21;
	localparam step_t ST_EMIT      = 5'd22;

	typedef enum logic [1:0] {
		WD_CELL,
		WD_BLANK,
		WD_BLANK_RST,
		WD_RDATA
	} wsel_t;

	typedef enum logic [1:0] {
		WA_CURSOR,
		WA_TARGET,
		WA_PTR,
		WA_PTR_LAG
	} waddr_t;

	typedef enum logic {
		RA_TARGET,
		RA_PTR_DOWN
	} raddr_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_ADV,
		CUR_NL,
		CUR_CR,
		CUR_DEC,
		CUR_SET,
		CUR_HOME
	} cur_op_t;

	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_CLR,
		PTR_INC,
		PTR_LAST_ROW
	} ptr_op_t;

	typedef enum logic [3:0] {
		C_TRUE,
		C_EOL_SCROLL,
		C_LAST_ROW,
		C_COL_ZERO,
		C_TGT_BAD,
		C_PTR_END,
		C_COPY_END,
		C_ONE_ROW,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		logic    disp;
		logic    we;
		wsel_t   wsel;
		waddr_t  waddr;
		raddr_t  raddr;
		cur_op_t cur;
		ptr_op_t ptr;
		logic    rd_cap;
		logic    out_load;
		cond_t   cond;
		step_t   tgt_t;
		step_t   tgt_f;
	} uword_t;

	function automatic uword_t ucode(step_t s);
		uword_t w;
		w = '0;
		w.cond = C_TRUE;
		w.tgt_t = ST_DISP;
		w.tgt_f = ST_DISP;
		unique case (s)
			ST_INIT: begin
				w.ptr = PTR_CLR;
				w.tgt_t = ST_INIT_LP;
			end
			ST_INIT_LP: begin
				w.we = 1'b1;
				w.wsel = WD_BLANK_RST;
				w.waddr = WA_PTR;
				w.ptr = PTR_INC;
				w.cond = C_PTR_END;
				w.tgt_t = ST_DISP;
				w.tgt_f = ST_INIT_LP;
			end
			ST_DISP: begin
				w.disp = 1'b1;
			end
			ST_PUT: begin
				w.we = 1'b1;
				w.wsel = WD_CELL;
				w.waddr = WA_CURSOR;
				w.cur = CUR_ADV;
				w.cond = C_EOL_SCROLL;
				w.tgt_t = ST_SC;
				w.tgt_f = ST_EMIT;
			end
			ST_NL: begin
				w.cur = CUR_NL;
				w.cond = C_LAST_ROW;
				w.tgt_t = ST_SC;
				w.tgt_f = ST_EMIT;
			end
			ST_CR: begin
				w.cur = CUR_CR;
				w.tgt_t = ST_EMIT;
			end
			ST_BS: begin
				w.cond = C_COL_ZERO;
				w.tgt_t = ST_EMIT;
				w.tgt_f = ST_BS_DEC;
			end
			ST_BS_DEC: begin
				w.cur = CUR_DEC;
				w.tgt_t = ST_BS_WR;
			end
			ST_BS_WR: begin
				w.we = 1'b1;
				w.wsel = WD_BLANK;
				w.waddr = WA_CURSOR;
				w.tgt_t = ST_EMIT;
			end
			ST_WC: begin
				w.cond = C_TGT_BAD;
				w.tgt_t = ST_EMIT;
				w.tgt_f = ST_WC_WR;
			end
			ST_WC_WR: begin
				w.we = 1'b1;
				w.wsel = WD_CELL;
				w.waddr = WA_TARGET;
				w.tgt_t = ST_EMIT;
			end
			ST_SET: begin
				w.cur = CUR_SET;
				w.tgt_t = ST_EMIT;
			end
			ST_CLR: begin
				w.cur = CUR_HOME;
				w.ptr = PTR_CLR;
				w.tgt_t = ST_CLR_LP;
			end
			ST_CLR_LP: begin
				w.we = 1'b1;
				w.wsel = WD_BLANK;
				w.waddr = WA_PTR;
				w.ptr = PTR_INC;
				w.cond = C_PTR_END;
				w.tgt_t = ST_EMIT;
				w.tgt_f = ST_CLR_LP;
			end
			ST_RD: begin
				w.cond = C_TGT_BAD;
				w.tgt_t = ST_EMIT;
				w.tgt_f = ST_RD_ADR;
			end
			ST_RD_ADR: begin
				w.raddr = RA_TARGET;
				w.tgt_t = ST_RD_CAP;
			end
			ST_RD_CAP: begin
				w.rd_cap = 1'b1;
				w.tgt_t = ST_EMIT;
			end
			ST_SC: begin
				w.ptr = PTR_CLR;
				w.cond = C_ONE_ROW;
				w.tgt_t = ST_SC_BLK;
				w.tgt_f = ST_SC_PRE;
			end
			ST_SC_PRE: begin
				w.raddr = RA_PTR_DOWN;
				w.ptr = PTR_INC;
				w.tgt_t = ST_SC_LP;
			end
			ST_SC_LP: begin
				w.we = 1'b1;
				w.wsel = WD_RDATA;
				w.waddr = WA_PTR_LAG;
				w.raddr = RA_PTR_DOWN;
				w.ptr = PTR_INC;
				w.cond = C_COPY_END;
				w.tgt_t = ST_SC_BLK;
				w.tgt_f = ST_SC_LP;
			end
			ST_SC_BLK: begin
				w.ptr = PTR_LAST_ROW;
				w.tgt_t = ST_SC_BLK_LP;
			end
			ST_SC_BLK_LP: begin
				w.we = 1'b1;
				w.wsel = WD_BLANK;
				w.waddr = WA_PTR;
				w.ptr = PTR_INC;
				w.cond = C_PTR_END;
				w.tgt_t = ST_EMIT;
				w.tgt_f = ST_SC_BLK_LP;
			end
			ST_EMIT: begin
				w.out_load = 1'b1;
				w.cond = C_OUT_BUSY;
				w.tgt_t = ST_EMIT;
				w.tgt_f = ST_DISP;
			end
			default: begin
				w.tgt_t = ST_DISP;
			end
		endcase
		return w;
	endfunction

	function automatic step_t entry(logic [2:0] rt, logic [7:0] ch);
		step_t s;
		s = ST_EMIT;
		unique case (rt)
			REQ_PUT: begin
				unique case (ch)
					CH_NEWLINE:   s = ST_NL;
					CH_RETURN:    s = ST_CR;
					CH_BACKSPACE: s = ST_BS;
					CH_TAB:       s = ST_EMIT;
					default:      s = ST_PUT;
				endcase
			end
			REQ_PUT_ATTR: s = ST_PUT;
			REQ_WRITE:    s = ST_WC;
			REQ_SET:      s = ST_SET;
			REQ_CLEAR:    s = ST_CLR;
			REQ_READ:     s = ST_RD;
			default:      s = ST_EMIT;
		endcase
		return s;
	endfunction

endpackage

// ===== hw/rtl/tccw_req_if.sv =====
interface tccw_req_if;
	logic                  valid;
	logic                  ready;
	tccw_pkg::req_item_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tccw_rsp_if.sv =====
interface tccw_rsp_if;
	logic                  valid;
	logic                  ready;
	tccw_pkg::rsp_item_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tccw_cfg_if.sv =====
interface tccw_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tccw_ram.sv =====
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/text_console_cell_writer.sv =====
// Text console cell writer: a ROWS x COLUMNS screen of 16-bit cells (attribute high byte,
// character low byte) with a cursor, run by a microcoded sequencer over one single-port-write,
// single-port-read cell RAM. After reset a clearing pass blanks the screen before the first
// request is taken. Each request yields one transfer reporting the cursor. Tab and ignored
// codes only report; backspace at column 0 and write cell out of range leave the screen
// unchanged, and read cell out of range returns zero. A put or newline that scrolls walks
// the RAM one cell per cycle. Clear blanks every cell and homes the cursor. The user must
// write the default attribute register only while no request is in flight; the block
// itself does not enforce it. The register is used for later blanks and plain characters.
module text_console_cell_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic         clk,
	input  logic         arst_n,
	tccw_req_if.sink     req,
	tccw_rsp_if.source   rsp,
	tccw_cfg_if.sink     cfg
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = CELLS > 1 ? $clog2(CELLS) : 1;
	localparam int PTR_W  = $clog2(CELLS + 1);
	localparam int ROW_W  = ROWS > 1 ? $clog2(ROWS) : 1;
	localparam int COL_W  = COLUMNS > 1 ? $clog2(COLUMNS) : 1;

	tccw_pkg::step_t     step_q;
	tccw_pkg::uword_t    uw;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [7:0]          def_attr_q;
	logic                out_valid_q;
	tccw_pkg::rsp_item_t out_q;
	logic [7:0]          ch_q;
	logic [7:0]          attr_q;
	logic [7:0]          trow_q;
	logic [7:0]          tcol_q;
	logic [15:0]         read_q;

	logic                in_take;
	logic                out_busy;
	logic                cond_ok;
	logic                tgt_ok;
	logic                row_last;
	logic                col_last;
	logic [ADDR_W-1:0]   cur_addr;
	logic [ADDR_W-1:0]   tgt_addr;
	logic [PTR_W-1:0]    lag_full;
	logic [PTR_W:0]      down_full;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [15:0]         ram_wdata;
	logic [15:0]         ram_rdata;

	assign uw = tccw_pkg::ucode(step_q);

	assign req.ready = (step_q == tccw_pkg::ST_DISP);
	assign in_take   = req.valid & req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
	assign out_busy  = out_valid_q & ~rsp.ready;

	assign tgt_ok    = (trow_q < 8'(ROWS)) && (tcol_q < 8'(COLUMNS));
	assign row_last  = (row_q == ROW_W'(ROWS - 1));
	assign col_last  = (col_q == COL_W'(COLUMNS - 1));
	assign cur_addr  = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q));
	assign tgt_addr  = ADDR_W'(ADDR_W'(ROW_W'(trow_q)) * ADDR_W'(COLUMNS)
		+ ADDR_W'(COL_W'(tcol_q)));
	assign lag_full  = ptr_q - PTR_W'(1);
	assign down_full = {1'b0, ptr_q} + (PTR_W + 1)'(COLUMNS);

	always_comb begin
		unique case (uw.cond)
			tccw_pkg::C_TRUE:       cond_ok = 1'b1;
			tccw_pkg::C_EOL_SCROLL: cond_ok = col_last & row_last;
			tccw_pkg::C_LAST_ROW:   cond_ok = row_last;
			tccw_pkg::C_COL_ZERO:   cond_ok = (col_q == '0);
			tccw_pkg::C_TGT_BAD:    cond_ok = ~tgt_ok;
			tccw_pkg::C_PTR_END:    cond_ok = (ptr_q == PTR_W'(CELLS - 1));
			tccw_pkg::C_COPY_END:   cond_ok = (ptr_q == PTR_W'(CELLS - COLUMNS));
			tccw_pkg::C_ONE_ROW:    cond_ok = (ROWS == 1);
			tccw_pkg::C_OUT_BUSY:   cond_ok = out_busy;
			default:                cond_ok = 1'b1;
		endcase
	end

	// cell ram ports
	assign ram_we = uw.we;

	always_comb begin
		unique case (uw.wsel)
			tccw_pkg::WD_CELL:      ram_wdata = {attr_q, ch_q};
			tccw_pkg::WD_BLANK:     ram_wdata = {def_attr_q, tccw_pkg::CH_SPACE};
			tccw_pkg::WD_BLANK_RST: ram_wdata = {tccw_pkg::ATTR_RESET, tccw_pkg::CH_SPACE};
			tccw_pkg::WD_RDATA:     ram_wdata = ram_rdata;
			default:                ram_wdata = ram_rdata;
		endcase
	end

	always_comb begin
		unique case (uw.waddr)
			tccw_pkg::WA_CURSOR:  ram_waddr = cur_addr;
			tccw_pkg::WA_TARGET:  ram_waddr = tgt_addr;
			tccw_pkg::WA_PTR:     ram_waddr = ptr_q[ADDR_W-1:0];
			tccw_pkg::WA_PTR_LAG: ram_waddr = lag_full[ADDR_W-1:0];
			default:              ram_waddr = ptr_q[ADDR_W-1:0];
		endcase
	end

	always_comb begin
		unique case (uw.raddr)
			tccw_pkg::RA_TARGET:   ram_raddr = tgt_addr;
			tccw_pkg::RA_PTR_DOWN: ram_raddr = down_full[ADDR_W-1:0];
			default:               ram_raddr = tgt_addr;
		endcase
	end

	tccw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer, cursor, pointer and result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= tccw_pkg::ST_INIT;
			row_q       <= '0;
			col_q       <= '0;
			ptr_q       <= '0;
			def_attr_q  <= tccw_pkg::ATTR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (uw.disp) begin
				step_q <= in_take ? tccw_pkg::entry(req.data.req_type, req.data.char_code)
					: tccw_pkg::ST_DISP;
			end else begin
				step_q <= cond_ok ? uw.tgt_t : uw.tgt_f;
			end

			if (cfg.valid) begin
				def_attr_q <= cfg.data;
			end

			unique case (uw.cur)
				tccw_pkg::CUR_HOLD: ;
				tccw_pkg::CUR_ADV: begin
					if (col_last) begin
						col_q <= '0;
						if (!row_last) begin
							row_q <= row_q + ROW_W'(1);
						end
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				tccw_pkg::CUR_NL: begin
					col_q <= '0;
					if (!row_last) begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				tccw_pkg::CUR_CR: col_q <= '0;
				tccw_pkg::CUR_DEC: col_q <= col_q - COL_W'(1);
				tccw_pkg::CUR_SET: begin
					row_q <= (trow_q < 8'(ROWS)) ? ROW_W'(trow_q) : ROW_W'(ROWS - 1);
					col_q <= (tcol_q < 8'(COLUMNS)) ? COL_W'(tcol_q) : COL_W'(COLUMNS - 1);
				end
				tccw_pkg::CUR_HOME: begin
					row_q <= '0;
					col_q <= '0;
				end
				default: ;
			endcase

			unique case (uw.ptr)
				tccw_pkg::PTR_HOLD:     ;
				tccw_pkg::PTR_CLR:      ptr_q <= '0;
				tccw_pkg::PTR_INC:      ptr_q <= ptr_q + PTR_W'(1);
				tccw_pkg::PTR_LAST_ROW: ptr_q <= PTR_W'(CELLS - COLUMNS);
				default:                ;
			endcase

			if (uw.out_load && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request fields and result payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			ch_q   <= req.data.char_code;
			attr_q <= (req.data.req_type == tccw_pkg::REQ_PUT) ? def_attr_q
				: req.data.cell_attr;
			trow_q <= req.data.target_row;
			tcol_q <= req.data.target_col;
			read_q <= '0;
		end else if (uw.rd_cap) begin
			read_q <= ram_rdata;
		end
		if (uw.out_load && !out_busy) begin
			out_q.cursor_row <= 5'(row_q);
			out_q.cursor_col <= 7'(col_q);
			out_q.read_data  <= read_q;
		end
	end

endmodule

// ===== dv/text_console_cell_writer_tb.sv =====
`timescale 1ns / 100ps

module text_console_cell_writer_tb;
	import tccw_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = ROWS * COLUMNS;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_LIMIT = 20000;
	localparam int SINK_HOLD_CYCLES = 400;

	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;

	typedef enum logic [1:0] {
		HOST_REQUEST,
		HOST_ATTR_WRITE,
		HOST_PAUSE
	} host_kind_t;

	typedef struct packed {
		host_kind_t kind;
		req_item_t  item;
		logic [7:0] attr;
		logic [3:0] gap;
	} host_action_t;

	logic clk;
	logic arst_n;

	tccw_req_if req_bus ();
	tccw_rsp_if rsp_bus ();
	tccw_cfg_if cfg_bus ();

	text_console_cell_writer #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus),
		.cfg(cfg_bus)
	);

	host_action_t host_actions[$];
	rsp_item_t cursor_reports[$];

	logic [15:0] screen_model [CELLS];
	int unsigned row_model;
	int unsigned col_model;
	logic [7:0] attr_model;

	logic req_took;
	logic rsp_took;
	logic cfg_took;
	logic sender_burst;
	logic sink_burst;
	int gap_left;
	int quiet_cycles;
	int sink_wait;
	int hold_left;
	int reports_seen;
	int mismatch_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.data = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		rsp_bus.ready = 1'b0;
		attr_model = ATTR_RESET;
		row_model = 0;
		col_model = 0;
		for (int i = 0; i < CELLS; i++)
			screen_model[i] = {ATTR_RESET, CH_SPACE};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// console predictor
	function automatic logic [15:0] blank_cell_value();
		return {attr_model, CH_SPACE};
	endfunction

	function automatic void settle_cursor();
		if (col_model >= COLUMNS) begin
			col_model = 0;
			row_model++;
		end
		if (row_model >= ROWS) begin
			for (int i = 0; i < CELLS - COLUMNS; i++)
				screen_model[i] = screen_model[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				screen_model[i] = blank_cell_value();
			row_model = ROWS - 1;
		end
	endfunction

	function automatic void write_at_cursor(logic [7:0] ch, logic [7:0] attr);
		screen_model[row_model * COLUMNS + col_model] = {attr, ch};
		col_model++;
		settle_cursor();
	endfunction

	function automatic rsp_item_t console_step(req_item_t r);
		rsp_item_t rep;
		logic [15:0] data;
		data = '0;
		case (r.req_type)
			REQ_PUT: begin
				case (r.char_code)
					CH_NEWLINE: begin
						row_model++;
						col_model = 0;
						settle_cursor();
					end
					CH_RETURN: col_model = 0;
					CH_BACKSPACE: begin
						if (col_model > 0) begin
							col_model--;
							screen_model[row_model * COLUMNS + col_model] = blank_cell_value();
						end
					end
					CH_TAB: ;
					default: write_at_cursor(r.char_code, attr_model);
				endcase
			end
			REQ_PUT_ATTR: write_at_cursor(r.char_code, r.cell_attr);
			REQ_WRITE: begin
				if (r.target_row < ROWS && r.target_col < COLUMNS)
					screen_model[r.target_row * COLUMNS + r.target_col] =
						{r.cell_attr, r.char_code};
			end
			REQ_SET: begin
				row_model = (r.target_row < ROWS) ? r.target_row : ROWS - 1;
				col_model = (r.target_col < COLUMNS) ? r.target_col : COLUMNS - 1;
			end
			REQ_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen_model[i] = blank_cell_value();
				row_model = 0;
				col_model = 0;
			end
			REQ_READ: begin
				if (r.target_row < ROWS && r.target_col < COLUMNS)
					data = screen_model[r.target_row * COLUMNS + r.target_col];
			end
			default: ;
		endcase
		rep.cursor_row = row_model[4:0];
		rep.cursor_col = col_model[6:0];
		rep.read_data = data;
		return rep;
	endfunction

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic push_request(input logic [2:0] code, input logic [7:0] ch,
			input logic [7:0] attr, input logic [7:0] row, input logic [7:0] col);
		host_action_t a;
		if ($urandom_range(0, 29) == 0)
			sender_burst = !sender_burst;
		a.kind = HOST_REQUEST;
		a.item.req_type = code;
		a.item.char_code = ch;
		a.item.cell_attr = attr;
		a.item.target_row = row;
		a.item.target_col = col;
		a.attr = '0;
		a.gap = sender_burst ? 4'd0 : 4'($urandom_range(0, 11));
		host_actions.push_back(a);
	endtask

	task automatic push_host_op(input host_kind_t kind, input logic [7:0] attr);
		host_action_t a;
		a = '0;
		a.kind = kind;
		a.attr = attr;
		host_actions.push_back(a);
	endtask

	// request and attribute driver
	always @(negedge clk) begin : host_driver
		logic nv;
		logic cv;
		req_item_t nd;
		logic [7:0] cd;
		if (arst_n) begin
			nv = req_bus.valid;
			nd = req_bus.data;
			cv = cfg_bus.valid;
			cd = cfg_bus.data;
			if (req_took)
				nv = 1'b0;
			if (cfg_took)
				cv = 1'b0;
			if (cursor_reports.size() == 0 && !nv && !cv)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (!nv && !cv && host_actions.size() != 0) begin
				if (gap_left < 0)
					gap_left = host_actions[0].gap;
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					case (host_actions[0].kind)
						HOST_REQUEST: begin
							nv = 1'b1;
							nd = host_actions[0].item;
							void'(host_actions.pop_front());
							gap_left = -1;
						end
						HOST_ATTR_WRITE: begin
							if (quiet_cycles >= SETTLE_CYCLES) begin
								cv = 1'b1;
								cd = host_actions[0].attr;
								void'(host_actions.pop_front());
								gap_left = -1;
							end
						end
						default: begin
							if (quiet_cycles >= SETTLE_CYCLES) begin
								void'(host_actions.pop_front());
								gap_left = -1;
							end
						end
					endcase
				end
			end
			req_bus.valid <= nv;
			req_bus.data <= nd;
			cfg_bus.valid <= cv;
			cfg_bus.data <= cd;
		end
	end

	// result sink with random stalls and long hold-offs
	always @(negedge clk) begin : report_sink
		logic nr;
		if (arst_n) begin
			nr = rsp_bus.ready;
			if (rsp_took) begin
				nr = 1'b0;
				reports_seen++;
				if ($urandom_range(0, 39) == 0)
					sink_burst = !sink_burst;
				sink_wait = sink_burst ? 0 : $urandom_range(0, 11);
				if (reports_seen % 500 == 250)
					hold_left = SINK_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				nr = 1'b0;
			end else if (!nr) begin
				if (sink_wait > 0) begin
					if (rsp_bus.valid)
						sink_wait--;
				end else begin
					nr = 1'b1;
				end
			end
			rsp_bus.ready <= nr;
		end
	end

	always @(posedge clk) begin : bus_monitor
		rsp_item_t want;
		req_took <= arst_n && req_bus.valid && req_bus.ready;
		rsp_took <= arst_n && rsp_bus.valid && rsp_bus.ready;
		cfg_took <= arst_n && cfg_bus.valid && cfg_bus.ready;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (cursor_reports.size() == 0) begin
					$error("unexpected result transfer %h", rsp_bus.data);
					mismatch_count++;
				end else begin
					want = cursor_reports.pop_front();
					if (rsp_bus.data.cursor_row !== want.cursor_row) begin
						$error("cursor_row: expected %0d, got %0d",
							want.cursor_row, rsp_bus.data.cursor_row);
						mismatch_count++;
					end
					if (rsp_bus.data.cursor_col !== want.cursor_col) begin
						$error("cursor_col: expected %0d, got %0d",
							want.cursor_col, rsp_bus.data.cursor_col);
						mismatch_count++;
					end
					if (rsp_bus.data.read_data !== want.read_data) begin
						$error("read_data: expected %h, got %h",
							want.read_data, rsp_bus.data.read_data);
						mismatch_count++;
					end
				end
			end
			if (cfg_bus.valid && cfg_bus.ready)
				attr_model = cfg_bus.data;
			if (req_bus.valid && req_bus.ready)
				cursor_reports.push_back(console_step(req_bus.data));
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
					|| (cfg_bus.valid && cfg_bus.ready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : scenario
		int pick;
		logic [2:0] code;
		logic [7:0] v;
		logic [7:0] ch;
		logic [7:0] attr;
		logic [7:0] row;
		logic [7:0] col;
		gap_left = -1;
		quiet_cycles = 0;
		sink_wait = 0;
		hold_left = 0;
		reports_seen = 0;
		mismatch_count = 0;
		sender_burst = 1'b0;
		sink_burst = 1'b0;
		req_took = 1'b0;
		rsp_took = 1'b0;
		cfg_took = 1'b0;

		push_host_op(HOST_ATTR_WRITE, 8'hA5);
		push_request(REQ_READ, any_byte(), any_byte(), 8'd0, 8'd0);
		push_request(REQ_PUT, 8'h41, any_byte(), any_byte(), any_byte());
		push_request(REQ_PUT, 8'hFF, any_byte(), any_byte(), any_byte());
		push_request(REQ_PUT, 8'h00, any_byte(), any_byte(), any_byte());
		push_request(REQ_PUT_ATTR, CH_NEWLINE, 8'hFF, any_byte(), any_byte());
		push_request(REQ_PUT_ATTR, 8'h00, 8'h00, any_byte(), any_byte());
		push_request(REQ_PUT, CH_TAB, any_byte(), any_byte(), any_byte());
		push_request(REQ_PUT, CH_BACKSPACE, any_byte(), any_byte(), any_byte());
		push_request(REQ_READ, any_byte(), any_byte(), 8'd0, 8'd4);
		push_request(REQ_PUT, CH_RETURN, any_byte(), any_byte(), any_byte());
		push_request(REQ_PUT, CH_BACKSPACE, any_byte(), any_byte(), any_byte());
		push_request(REQ_PUT, CH_NEWLINE, any_byte(), any_byte(), any_byte());
		push_request(REQ_WRITE, 8'hFF, 8'hFF, 8'(ROWS - 1), 8'(COLUMNS - 1));
		push_request(REQ_WRITE, any_byte(), any_byte(), 8'(ROWS), 8'd0);
		push_request(REQ_WRITE, any_byte(), any_byte(), 8'd0, 8'(COLUMNS));
		push_request(REQ_WRITE, any_byte(), any_byte(), 8'hFF, 8'hFF);
		push_request(REQ_READ, any_byte(), any_byte(), 8'(ROWS - 1), 8'(COLUMNS - 1));
		push_request(REQ_READ, any_byte(), any_byte(), 8'(ROWS), 8'd0);
		push_request(REQ_READ, any_byte(), any_byte(), 8'hFF, 8'hFF);
		push_request(REQ_SET, any_byte(), any_byte(), 8'hFF, 8'hFF);
		push_request(REQ_PUT, 8'h78, any_byte(), any_byte(), any_byte());
		push_request(REQ_READ, any_byte(), any_byte(), 8'(ROWS - 2), 8'(COLUMNS - 1));
		push_request(REQ_SET, any_byte(), any_byte(), 8'(ROWS - 1), 8'd3);
		push_request(REQ_PUT, CH_NEWLINE, any_byte(), any_byte(), any_byte());
		push_request(REQ_CLEAR, any_byte(), any_byte(), any_byte(), any_byte());
		push_request(REQ_READ, any_byte(), any_byte(), 8'd12, 8'd40);
		push_request(REQ_SPARE_LO, any_byte(), any_byte(), any_byte(), any_byte());
		push_request(REQ_SPARE_HI, any_byte(), any_byte(), any_byte(), any_byte());

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: v = 8'h00;
				1: v = 8'hFF;
				3: v = ATTR_RESET;
				default: v = any_byte();
			endcase
			push_host_op(HOST_ATTR_WRITE, v);
			for (int n = 0; n < 200; n++) begin
				if (p == 2 && n == 100)
					push_host_op(HOST_PAUSE, '0);
				pick = $urandom_range(0, 99);
				code = REQ_PUT;
				ch = any_byte();
				attr = any_byte();
				row = any_byte();
				col = any_byte();
				if (pick < 35) begin
					if ($urandom_range(0, 3) == 0) begin
						case ($urandom_range(0, 3))
							0: ch = CH_NEWLINE;
							1: ch = CH_RETURN;
							2: ch = CH_BACKSPACE;
							default: ch = CH_TAB;
						endcase
					end
				end else if (pick < 55) begin
					code = REQ_PUT_ATTR;
				end else if (pick < 65) begin
					code = REQ_WRITE;
					if ($urandom_range(0, 4) != 0) begin
						row = 8'($urandom_range(0, ROWS - 1));
						col = 8'($urandom_range(0, COLUMNS - 1));
					end
				end else if (pick < 75) begin
					code = REQ_SET;
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: begin
							row = 8'($urandom_range(0, ROWS - 1));
							col = 8'($urandom_range(0, COLUMNS - 1));
						end
						5, 6: begin
							row = 8'(ROWS - 1);
							col = 8'($urandom_range(COLUMNS - 4, COLUMNS - 1));
						end
						default: ;
					endcase
				end else if (pick < 92) begin
					code = REQ_READ;
					if ($urandom_range(0, 19) > 2) begin
						row = 8'($urandom_range(0, ROWS - 1));
						col = 8'($urandom_range(0, COLUMNS - 1));
					end
				end else if (pick < 94) begin
					code = REQ_CLEAR;
				end else if (pick < 97) begin
					code = ($urandom_range(0, 1) == 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
				end
				push_request(code, ch, attr, row, col);
			end
		end

		@(posedge clk);
		while (host_actions.size() != 0 || req_bus.valid || cursor_reports.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (cursor_reports.size() != 0) begin
			$error("%0d results never arrived", cursor_reports.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
